// File: rtl/qrs_pkg.sv
`timescale 1ns / 1ps
package qrs_pkg;

    localparam int COEF_WIDTH = 16;
    localparam int OUT_WIDTH  = 32;
    localparam int FRAC_SHIFT = 16;

    localparam int PROD_W  = 2 * COEF_WIDTH;
    localparam int DISC_W  = 2 * COEF_WIDTH + 2;
    localparam int DMAG_W  = 2 * COEF_WIDTH + 1;
    localparam int SQRT_W  = (DMAG_W + 1) / 2;
    localparam int NUM_W   = COEF_WIDTH + 3;
    localparam int NMAG_W  = NUM_W - 1;
    localparam int DEN_W   = COEF_WIDTH + 1;
    localparam int DVD_W   = NMAG_W + FRAC_SHIFT;

    localparam int SQ_LAT  = SQRT_W + 1;
    localparam int DV_LAT  = DVD_W + 1;
    localparam int LATENCY = 2 + SQ_LAT + 1 + DV_LAT + 1;

    typedef enum logic [1:0] {
        KIND_TWO     = 2'd0,
        KIND_SAME    = 2'd1,
        KIND_COMPLEX = 2'd2,
        KIND_BAD     = 2'd3
    } t_kind;

    typedef struct packed {
        logic signed [COEF_WIDTH-1:0] coef_a;
        logic signed [COEF_WIDTH-1:0] coef_b;
        logic signed [COEF_WIDTH-1:0] coef_c;
    } t_coef_in;

    typedef struct packed {
        t_kind                       root_kind;
        logic signed [OUT_WIDTH-1:0] first_value;
        logic signed [OUT_WIDTH-1:0] second_value;
    } t_root_out;

    typedef struct packed {
        t_kind                        kind;
        logic signed [COEF_WIDTH-1:0] a;
        logic signed [NUM_W-1:0]      nb;
    } t_side;

    typedef struct packed {
        t_kind kind;
        logic  neg1;
        logic  neg2;
    } t_mid;

    function automatic logic signed [OUT_WIDTH-1:0] sat_q(input logic [DVD_W-1:0] q,
                                                         input logic neg);
        logic big_pos;
        logic big_neg;
        logic signed [OUT_WIDTH-1:0] res;
        big_pos = |q[DVD_W-1:OUT_WIDTH-1];
        big_neg = big_pos;
        if (neg) begin
            if (big_neg) begin
                res = {1'b1, {(OUT_WIDTH-1){1'b0}}};
            end else begin
                res = -$signed(q[OUT_WIDTH-1:0]);
            end
        end else begin
            if (big_pos) begin
                res = {1'b0, {(OUT_WIDTH-1){1'b1}}};
            end else begin
                res = $signed(q[OUT_WIDTH-1:0]);
            end
        end
        return res;
    endfunction

endpackage

// File: rtl/qrs_sqrt.sv
`timescale 1ns / 1ps
module qrs_sqrt (
    input  logic                       i_clk,
    input  logic [qrs_pkg::DMAG_W-1:0] i_mag,
    output logic [qrs_pkg::SQRT_W-1:0] o_root
);
    import qrs_pkg::*;

    localparam int XW = 2 * SQRT_W;
    localparam int RW = SQRT_W + 2;

    logic [XW-1:0]     r_x    [0:SQRT_W];
    logic [RW-1:0]     r_rem  [0:SQRT_W];
    logic [SQRT_W-1:0] r_root [0:SQRT_W];
    logic [XW-1:0]     n_x    [1:SQRT_W];
    logic [RW-1:0]     n_rem  [1:SQRT_W];
    logic [SQRT_W-1:0] n_root [1:SQRT_W];

    // one result bit per stage
    always_comb begin
        logic [RW+1:0] cur;
        logic [RW+1:0] trial;
        for (int k = 1; k <= SQRT_W; k++) begin
            cur   = {r_rem[k-1], r_x[k-1][XW-1:XW-2]};
            trial = (RW+2)'({r_root[k-1], 2'b01});
            n_x[k] = r_x[k-1] << 2;
            if (cur >= trial) begin
                n_rem[k]  = RW'(cur - trial);
                n_root[k] = {r_root[k-1][SQRT_W-2:0], 1'b1};
            end else begin
                n_rem[k]  = RW'(cur);
                n_root[k] = {r_root[k-1][SQRT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_x[0]    <= XW'(i_mag);
        r_rem[0]  <= '0;
        r_root[0] <= '0;
        for (int k = 1; k <= SQRT_W; k++) begin
            r_x[k]    <= n_x[k];
            r_rem[k]  <= n_rem[k];
            r_root[k] <= n_root[k];
        end
    end

    assign o_root = r_root[SQRT_W];

endmodule

// File: rtl/qrs_div.sv
`timescale 1ns / 1ps
module qrs_div (
    input  logic                      i_clk,
    input  logic [qrs_pkg::DVD_W-1:0] i_num,
    input  logic [qrs_pkg::DEN_W-1:0] i_den,
    output logic [qrs_pkg::DVD_W-1:0] o_quot
);
    import qrs_pkg::*;

    localparam int RW = DEN_W + 1;

    logic [DVD_W-1:0] r_n   [0:DVD_W];
    logic [DEN_W-1:0] r_d   [0:DVD_W];
    logic [RW-1:0]    r_rem [0:DVD_W];
    logic [DVD_W-1:0] r_q   [0:DVD_W];
    logic [DVD_W-1:0] n_n   [1:DVD_W];
    logic [RW-1:0]    n_rem [1:DVD_W];
    logic [DVD_W-1:0] n_q   [1:DVD_W];

    // restoring division, one quotient bit per stage
    always_comb begin
        logic [RW:0] cur;
        for (int k = 1; k <= DVD_W; k++) begin
            cur    = {r_rem[k-1], r_n[k-1][DVD_W-1]};
            n_n[k] = r_n[k-1] << 1;
            if (cur >= (RW+1)'(r_d[k-1])) begin
                n_rem[k] = RW'(cur - (RW+1)'(r_d[k-1]));
                n_q[k]   = {r_q[k-1][DVD_W-2:0], 1'b1};
            end else begin
                n_rem[k] = RW'(cur);
                n_q[k]   = {r_q[k-1][DVD_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_n[0]   <= i_num;
        r_d[0]   <= i_den;
        r_rem[0] <= '0;
        r_q[0]   <= '0;
        for (int k = 1; k <= DVD_W; k++) begin
            r_n[k]   <= n_n[k];
            r_d[k]   <= r_d[k-1];
            r_rem[k] <= n_rem[k];
            r_q[k]   <= n_q[k];
        end
    end

    assign o_quot = r_q[DVD_W];

endmodule

// File: rtl/quadratic_root_solver.sv
`timescale 1ns / 1ps
// Quadratic root solver, fully pipelined.
// Input: drive i_coef (a, b, c as signed Q8.8) and pulse i_start. A beat is
// taken at every rising edge with i_start high and o_busy low; o_busy is
// always low, so one coefficient set can enter every cycle.
// Output: o_valid is high for exactly one cycle with the result beat on
// o_result: root kind and two Q16.16 values, saturated.
// Pipeline, from the accepting edge to the edge that takes the result: the
// product and discriminant registers, the bit-per-stage square root, the
// numerator register, the bit-per-stage dividers and the saturation register.
// Throughput: one beat per cycle, set by the one-stage-per-bit sqrt and
// divider pipelines.
// Reset: synchronous active-low i_rst_n clears all valid bits in flight;
// items inside the pipe at reset are dropped.
// The receiver cannot stall, so results leave exactly in order of entry.
module quadratic_root_solver (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  qrs_pkg::t_coef_in i_coef,
    output logic              o_busy,
    output logic              o_valid,
    output qrs_pkg::t_root_out o_result
);
    import qrs_pkg::*;

    localparam int W = COEF_WIDTH;

    logic                     r1_vld;
    logic [PROD_W-1:0]        r1_bb;
    logic signed [PROD_W-1:0] r1_ac;
    logic signed [W-1:0]      r1_a;
    logic signed [W-1:0]      r1_b;
    logic [W-1:0]             b_mag;

    logic                     r2_vld;
    logic [DMAG_W-1:0]        r2_dmag;
    t_side                    r2_side;
    logic signed [DISC_W-1:0] disc;
    t_side                    n2_side;

    logic                     r_sv [0:SQ_LAT-1];
    t_side                    r_sd [0:SQ_LAT-1];
    logic [SQRT_W-1:0]        sq_root;

    logic                     r3_vld;
    t_mid                     r3_mid;
    logic [DVD_W-1:0]         r3_num1;
    logic [DVD_W-1:0]         r3_num2;
    logic [DEN_W-1:0]         r3_den;
    t_mid                     n3_mid;
    logic signed [NUM_W-1:0]  num1;
    logic signed [NUM_W-1:0]  num2;
    logic [W-1:0]             a_mag;
    logic                     is_cplx;

    logic                     r_dv [0:DV_LAT-1];
    t_mid                     r_dm [0:DV_LAT-1];
    logic [DVD_W-1:0]         q1;
    logic [DVD_W-1:0]         q2;

    logic                     r_vld;
    t_root_out                r_res;
    t_root_out                n_res;

    assign b_mag = i_coef.coef_b[W-1] ? W'(-i_coef.coef_b) : W'(i_coef.coef_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= i_start;
        end
        r1_bb <= PROD_W'(b_mag) * PROD_W'(b_mag);
        r1_ac <= PROD_W'(i_coef.coef_a) * PROD_W'(i_coef.coef_c);
        r1_a  <= i_coef.coef_a;
        r1_b  <= i_coef.coef_b;
    end

    always_comb begin
        disc = $signed(DISC_W'(r1_bb)) - (DISC_W'(r1_ac) <<< 2);
        n2_side.a  = r1_a;
        n2_side.nb = -NUM_W'(r1_b);
        if (r1_a == '0) begin
            n2_side.kind = KIND_BAD;
        end else if (disc < 0) begin
            n2_side.kind = KIND_COMPLEX;
        end else if (disc == '0) begin
            n2_side.kind = KIND_SAME;
        end else begin
            n2_side.kind = KIND_TWO;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else begin
            r2_vld <= r1_vld;
        end
        r2_dmag <= disc[DISC_W-1] ? DMAG_W'(-disc) : DMAG_W'(disc);
        r2_side <= n2_side;
    end

    qrs_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_mag  (r2_dmag),
        .o_root (sq_root)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SQ_LAT; k++) r_sv[k] <= 1'b0;
        end else begin
            r_sv[0] <= r2_vld;
            for (int k = 1; k < SQ_LAT; k++) r_sv[k] <= r_sv[k-1];
        end
        r_sd[0] <= r2_side;
        for (int k = 1; k < SQ_LAT; k++) r_sd[k] <= r_sd[k-1];
    end

    always_comb begin
        is_cplx = (r_sd[SQ_LAT-1].kind == KIND_COMPLEX);
        a_mag   = r_sd[SQ_LAT-1].a[W-1] ? W'(-r_sd[SQ_LAT-1].a) : W'(r_sd[SQ_LAT-1].a);
        if (is_cplx) begin
            num1 = r_sd[SQ_LAT-1].nb;
            num2 = $signed(NUM_W'(sq_root));
        end else begin
            num1 = r_sd[SQ_LAT-1].nb + $signed(NUM_W'(sq_root));
            num2 = r_sd[SQ_LAT-1].nb - $signed(NUM_W'(sq_root));
        end
        n3_mid.kind = r_sd[SQ_LAT-1].kind;
        n3_mid.neg1 = num1[NUM_W-1] ^ r_sd[SQ_LAT-1].a[W-1];
        n3_mid.neg2 = num2[NUM_W-1] ^ (r_sd[SQ_LAT-1].a[W-1] & !is_cplx);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else begin
            r3_vld <= r_sv[SQ_LAT-1];
        end
        r3_mid  <= n3_mid;
        r3_num1 <= {NMAG_W'(num1[NUM_W-1] ? -num1 : num1), {FRAC_SHIFT{1'b0}}};
        r3_num2 <= {NMAG_W'(num2[NUM_W-1] ? -num2 : num2), {FRAC_SHIFT{1'b0}}};
        r3_den  <= {a_mag, 1'b0};
    end

    qrs_div u_div1 (
        .i_clk  (i_clk),
        .i_num  (r3_num1),
        .i_den  (r3_den),
        .o_quot (q1)
    );

    qrs_div u_div2 (
        .i_clk  (i_clk),
        .i_num  (r3_num2),
        .i_den  (r3_den),
        .o_quot (q2)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DV_LAT; k++) r_dv[k] <= 1'b0;
        end else begin
            r_dv[0] <= r3_vld;
            for (int k = 1; k < DV_LAT; k++) r_dv[k] <= r_dv[k-1];
        end
        r_dm[0] <= r3_mid;
        for (int k = 1; k < DV_LAT; k++) r_dm[k] <= r_dm[k-1];
    end

    always_comb begin
        n_res.root_kind = r_dm[DV_LAT-1].kind;
        if (r_dm[DV_LAT-1].kind == KIND_BAD) begin
            n_res.first_value  = '0;
            n_res.second_value = '0;
        end else begin
            n_res.first_value  = sat_q(q1, r_dm[DV_LAT-1].neg1);
            n_res.second_value = sat_q(q2, r_dm[DV_LAT-1].neg2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= r_dv[DV_LAT-1];
        end
        r_res <= n_res;
    end

    assign o_busy   = 1'b0;
    assign o_valid  = r_vld;
    assign o_result = r_res;

`ifndef SYNTHESIS
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start, LATENCY))
        else $error("result beat without matching input beat");
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.root_kind == KIND_BAD) |->
        (o_result.first_value == '0 && o_result.second_value == '0))
        else $error("zero a gave nonzero values");
    a_imag_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.root_kind == KIND_COMPLEX) |-> !o_result.second_value[OUT_WIDTH-1])
        else $error("negative imaginary magnitude");
    a_same_eq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.root_kind == KIND_SAME) |->
        (o_result.first_value == o_result.second_value))
        else $error("repeated root values differ");
`endif

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import qrs_pkg::*;

    class root_board;
        t_root_out pending[$];
        int errors;

        function new();
            errors = 0;
        endfunction

        static function logic signed [31:0] quot_q16(longint num, longint den);
            longint nm;
            longint dm;
            longint q;
            nm = num < 0 ? -num : num;
            dm = den < 0 ? -den : den;
            q = (nm <<< 16) / dm;
            if ((num < 0) != (den < 0)) begin
                if (q >= 64'sh80000000) return 32'sh80000000;
                return 32'(-q);
            end
            if (q > 64'sh7FFFFFFF) return 32'sh7FFFFFFF;
            return 32'(q);
        endfunction

        static function longint floor_sqrt(longint n);
            longint lo;
            longint hi;
            longint mid;
            lo = 0;
            hi = 64'sd4294967296;
            while (lo < hi) begin
                mid = (lo + hi + 1) / 2;
                if (mid * mid <= n) lo = mid;
                else hi = mid - 1;
            end
            return lo;
        endfunction

        function void note_coef(t_coef_in x);
            t_root_out e;
            longint a;
            longint b;
            longint c;
            longint d;
            longint s;
            a = x.coef_a;
            b = x.coef_b;
            c = x.coef_c;
            if (a == 0) begin
                e.root_kind = KIND_BAD;
                e.first_value = 0;
                e.second_value = 0;
            end else begin
                d = b * b - 4 * a * c;
                s = floor_sqrt(d < 0 ? -d : d);
                if (d < 0) begin
                    e.root_kind = KIND_COMPLEX;
                    e.first_value = quot_q16(-b, 2 * a);
                    e.second_value = quot_q16(s, a < 0 ? -2 * a : 2 * a);
                end else if (d == 0) begin
                    e.root_kind = KIND_SAME;
                    e.first_value = quot_q16(-b, 2 * a);
                    e.second_value = e.first_value;
                end else begin
                    e.root_kind = KIND_TWO;
                    e.first_value = quot_q16(-b + s, 2 * a);
                    e.second_value = quot_q16(-b - s, 2 * a);
                end
            end
            pending.push_back(e);
        endfunction

        task automatic check_root(t_root_out r);
            t_root_out e;
            if (pending.size() == 0) begin
                report_err("result beat with nothing expected");
                return;
            end
            e = pending.pop_front();
            if (r.root_kind !== e.root_kind)
                report_err($sformatf("kind got %0d exp %0d", r.root_kind, e.root_kind));
            if (r.first_value !== e.first_value)
                report_err($sformatf("first got %0d exp %0d", r.first_value, e.first_value));
            if (r.second_value !== e.second_value)
                report_err($sformatf("second got %0d exp %0d", r.second_value,
                                     e.second_value));
        endtask

        task automatic report_err(string msg);
            errors++;
            $display("ERROR %0t: %s", $realtime, msg);
        endtask
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      i_start;
    t_coef_in  i_coef;
    logic      o_busy;
    logic      o_valid;
    t_root_out o_result;

    root_board board;
    int idle_cycles;

    quadratic_root_solver dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_coef  (i_coef),
        .o_busy  (o_busy),
        .o_valid (o_valid),
        .o_result(o_result)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_start && !o_busy) board.note_coef(i_coef);
            if (o_valid) board.check_root(o_result);
            if ((i_start && !o_busy) || o_valid) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles > 2000) begin
                    $display("quadratic_root_solver test failed");
                    $finish;
                end
            end
        end
    end

    function automatic logic [15:0] pick_coef();
        case ($urandom_range(0, 9))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'sd0;
            3: return 16'($urandom_range(0, 15) - 8);
            4, 5: return 16'($urandom_range(0, 2047) - 1024);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_coef(logic [15:0] a, logic [15:0] b, logic [15:0] c);
        i_start <= 1'b1;
        i_coef  <= '{coef_a: a, coef_b: b, coef_c: c};
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic pause_gap(int n);
        i_start <= 1'b0;
        i_coef  <= '{coef_a: 16'($urandom), coef_b: 16'($urandom), coef_c: 16'($urandom)};
        repeat (n) @(negedge i_clk);
    endtask

    task automatic drain_all();
        int guard;
        pause_gap(1);
        guard = 0;
        while (board.pending.size() != 0 && guard < 5 * LATENCY + 100) begin
            @(negedge i_clk);
            guard++;
        end
    endtask

    initial begin
        logic signed [15:0] r;
        int burst;
        board = new();
        idle_cycles = 0;
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_coef  = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        send_coef(16'sh0100, 16'sh0000, 16'shFF00);
        send_coef(16'sh0100, 16'shFE00, 16'sh0100);
        send_coef(16'sh0100, 16'sh0000, 16'sh0100);
        send_coef(16'sh0000, 16'sh1234, 16'sh5678);
        send_coef(16'sh0000, 16'sh0000, 16'sh0000);
        send_coef(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        send_coef(16'sh8000, 16'sh8000, 16'sh8000);
        send_coef(16'sh8000, 16'sh7FFF, 16'sh7FFF);
        send_coef(16'sh7FFF, 16'sh8000, 16'sh8000);
        send_coef(16'sh0001, 16'sh7FFF, 16'sh0000);
        send_coef(16'shFFFF, 16'sh8000, 16'sh0000);
        send_coef(16'sh0001, 16'sh8000, 16'sh7FFF);
        send_coef(16'shFFFF, 16'sh0000, 16'sh8000);
        send_coef(16'sh0001, 16'sh0002, 16'sh0001);
        send_coef(16'sh0001, 16'sh0003, 16'sh0002);
        send_coef(16'shFFFF, 16'sh0001, 16'sh0001);
        send_coef(16'sh0002, 16'sh0003, 16'sh0001);
        send_coef(16'sh0100, 16'shFFFF, 16'sh0000);
        send_coef(16'shFFFF, 16'shFFFF, 16'shFFFF);
        send_coef(16'sh5555, 16'shAAAA, 16'sh5555);
        drain_all();

        for (int i = 0; i < 1250; i++) begin
            if (i == 600) drain_all();
            burst = $urandom_range(0, 3);
            if (burst == 0 && i % 7 == 0) pause_gap($urandom_range(1, 6));
            case ($urandom_range(0, 4))
                0: begin
                    // repeated root: b = 2r*k, c = r*r*k style with a = k
                    r = 16'($urandom_range(0, 64) - 32);
                    send_coef(16'sd1, 16'(2 * r), r * r);
                end
                default: send_coef(pick_coef(), pick_coef(), pick_coef());
            endcase
        end
        drain_all();
        pause_gap(LATENCY + 10);

        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("quadratic_root_solver test passed");
        end else begin
            $display("quadratic_root_solver test failed");
        end
        $finish;
    end
endmodule
